// ===== rtl/core/bcls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcls_pkg
// Shared types and constants of the block code length search core.
// ----------------------------------------------------------------------------
package bcls_pkg;

  localparam int SEARCH_LEVELS = 24;
  localparam int LVL_W         = 5;
  localparam int DIGIT_W       = 3;
  localparam int COST_W        = 64;
  localparam int FREQ_W        = 32;
  localparam int CL_W          = 7;

  localparam logic [LVL_W-1:0]   LAST_LEVEL = LVL_W'(SEARCH_LEVELS - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_TWO  = 3'd2;
  localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 3'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_VISIT,
    ST_RD_BOT,
    ST_RD_TOP,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic leaf;
    logic pop;
    logic choose;
    logic rd_bot;
    logic rd_top;
    logic calc;
    logic emit_next;
    logic clear_count;
  } cmd_t;

  typedef struct packed {
    logic leaf;
    logic can_try;
    logic at_root;
    logic last_slot;
  } status_t;

endpackage

// ===== rtl/core/bcls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcls_ctrl
// Sequencer: load phase, depth-first search steps and result emission.
// ----------------------------------------------------------------------------
module bcls_ctrl
  import bcls_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    is_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && is_last) state_next = ST_INIT;
      end
      ST_INIT: state_next = ST_VISIT;
      ST_VISIT: begin
        priority if (status.leaf) begin
          state_next = status.at_root ? ST_EMIT : ST_VISIT;
        end else if (status.can_try) begin
          state_next = ST_RD_BOT;
        end else begin
          state_next = status.at_root ? ST_EMIT : ST_VISIT;
        end
      end
      ST_RD_BOT: state_next = ST_RD_TOP;
      ST_RD_TOP: state_next = ST_CALC;
      ST_CALC:   state_next = ST_VISIT;
      ST_EMIT: begin
        if (out_ready && status.last_slot) state_next = ST_LOAD;
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_INIT: cmd.init = 1'b1;
      ST_VISIT: begin
        priority if (status.leaf) begin
          cmd.leaf = 1'b1;
          cmd.pop  = !status.at_root;
        end else if (status.can_try) begin
          cmd.choose = 1'b1;
        end else begin
          cmd.pop = !status.at_root;
        end
      end
      ST_RD_BOT: cmd.rd_bot = 1'b1;
      ST_RD_TOP: cmd.rd_top = 1'b1;
      ST_CALC:   cmd.calc = 1'b1;
      ST_EMIT: begin
        out_valid       = 1'b1;
        cmd.emit_next   = out_ready;
        cmd.clear_count = out_ready && status.last_slot;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/bcls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcls_dp
// Datapath: prefix sum memory, search frame stack, digit arrays, best tracker.
// ----------------------------------------------------------------------------
module bcls_dp
  import bcls_pkg::*;
#(
  parameter int MAX_SYMBOLS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [FREQ_W-1:0]   frequency,
  output status_t             status,
  output logic [LVL_W-1:0]    slot,
  output logic [DIGIT_W-1:0]  digit_bits,
  output logic [COST_W-1:0]   best_bits,
  output logic [LVL_W-1:0]    blocks_used,
  output logic                found
);

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int PW = CL_W + 1 + FREQ_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SYMBOLS);

  logic [FREQ_W-1:0] prefix_mem [MAX_SYMBOLS];
  logic [FREQ_W-1:0] rdata;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     count;
  logic [FREQ_W-1:0] sum;
  logic [FREQ_W-1:0] sum_next;
  logic [FREQ_W-1:0] bot;

  logic [COST_W-1:0]  fstart  [SEARCH_LEVELS];
  logic [COST_W-1:0]  finc    [SEARCH_LEVELS];
  logic [CL_W-1:0]    fcl     [SEARCH_LEVELS];
  logic [COST_W-1:0]  fcost   [SEARCH_LEVELS];
  logic [DIGIT_W-1:0] fchoice [SEARCH_LEVELS];
  logic [DIGIT_W-1:0] working [SEARCH_LEVELS];
  logic [DIGIT_W-1:0] best    [SEARCH_LEVELS];
  logic [COST_W-1:0]  best_cost;
  logic [LVL_W-1:0]   best_level;
  logic [LVL_W-1:0]   d;
  logic               fresh;

  logic [COST_W-1:0]  st, inc, cost, hi, n64, top64, cost_new, inc_new;
  logic [DIGIT_W-1:0] lw, hw, w, nw;
  logic [CL_W:0]      cl;
  logic [FREQ_W-1:0]  top, range;
  logic [PW-1:0]      prod;
  logic [3:0]         factor;
  logic               is_leaf;

  assign st    = fstart[d];
  assign inc   = finc[d];
  assign cost  = fcost[d];
  assign w     = fchoice[d];
  assign n64   = COST_W'(count);
  assign hi    = st + inc - 64'd1;
  assign lw    = (d >= 5'd4 && d < 5'd8) ? 3'd1 : 3'd2;
  assign hw    = (d < 5'd4) ? 3'd4 : 3'd2;
  assign nw    = fresh ? lw : w + 3'd1;

  assign is_leaf = fresh && (st > n64);

  always_comb begin
    status.leaf      = is_leaf;
    status.can_try   = fresh ? !is_leaf : (w < hw);
    status.at_root   = (d == '0);
    status.last_slot = (slot == LAST_LEVEL);
  end

  // entries at or beyond n read as the total
  assign top      = (hi >= n64) ? sum : rdata;
  assign range    = top - bot;
  assign cl       = {1'b0, fcl[d]} + (CL_W+1)'(w);
  assign prod     = PW'(cl) * PW'(range);
  assign cost_new = cost + COST_W'(prod);
  assign factor   = (4'd1 << w) - 4'd1;
  assign inc_new  = inc * COST_W'(factor);
  assign top64    = 64'(st == '0 ? '0 : st - 64'd1);

  assign sum_next = ((count == '0) ? '0 : sum) + frequency;

  always_comb begin
    raddr = cmd.rd_bot ? top64[AW-1:0] : hi[AW-1:0];
  end

  always_ff @(posedge clk) begin
    rdata <= prefix_mem[raddr];
    if (cmd.load && count < MAX_COUNT) begin
      prefix_mem[count[AW-1:0]] <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      slot  <= '0;
    end else begin
      if (cmd.load && count < MAX_COUNT) count <= count + CW'(1);
      if (cmd.clear_count) count <= '0;
      if (cmd.emit_next) slot <= status.last_slot ? '0 : slot + LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && count < MAX_COUNT) sum <= sum_next;
    if (cmd.rd_top) bot <= (st == '0) ? '0 : rdata;

    if (cmd.init) begin
      d          <= '0;
      fresh      <= 1'b1;
      fstart[0]  <= '0;
      finc[0]    <= 64'd1;
      fcl[0]     <= '0;
      fcost[0]   <= '0;
      best_cost  <= '1;
      best_level <= '0;
      for (int k = 0; k < SEARCH_LEVELS; k++) begin
        working[k] <= DIGIT_TWO;
        best[k]    <= DIGIT_TWO;
      end
    end

    if (cmd.leaf) begin
      working[d] <= DIGIT_ONE;
      if (cost < best_cost) begin
        best_cost  <= cost;
        best_level <= d - LVL_W'(1);
        for (int k = 0; k < SEARCH_LEVELS; k++) begin
          best[k] <= (LVL_W'(k) == d) ? DIGIT_ONE : working[k];
        end
      end
    end

    if (cmd.pop) begin
      d     <= d - LVL_W'(1);
      fresh <= 1'b0;
    end

    if (cmd.choose) begin
      fchoice[d] <= nw;
      working[d] <= nw;
    end

    if (cmd.calc) begin
      if (d < LAST_LEVEL) begin
        fstart[d + LVL_W'(1)] <= st + inc;
        finc[d + LVL_W'(1)]   <= inc_new;
        fcl[d + LVL_W'(1)]    <= cl[CL_W-1:0];
        fcost[d + LVL_W'(1)]  <= cost_new;
        d                     <= d + LVL_W'(1);
        fresh                 <= 1'b1;
      end else begin
        fresh <= 1'b0;
      end
    end
  end

  assign digit_bits  = best[slot];
  assign best_bits   = best_cost;
  assign blocks_used = best_level;
  assign found       = (best_cost != '1);

endmodule

// ===== rtl/core/block_code_length_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_code_length_search_core
// Loads symbol frequencies, searches block widths, emits the best digit array.
// ----------------------------------------------------------------------------
// Frequencies are taken one per cycle into a prefix sum memory with one write
// port and one registered read port. After the transfer marked is_last the
// core runs a depth-first search: each descent picks a digit, reads the
// prefix memory twice (one read per range end), then updates the cost; each
// leaf or backtrack is handled in the visit state. It then presents 24
// results, one per cycle when the sink is ready, and returns to loading.
// in_ready is low from the last input transfer until the final result transfer.
module block_code_length_search_core
  import bcls_pkg::*;
#(
  parameter int MAX_SYMBOLS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FREQ_W-1:0]   frequency,
  input  logic                is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LVL_W-1:0]    slot,
  output logic [DIGIT_W-1:0]  digit_bits,
  output logic [COST_W-1:0]   best_bits,
  output logic [LVL_W-1:0]    blocks_used,
  output logic                found,
  output logic                last_result
);

  cmd_t    cmd;
  status_t status;

  bcls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcls_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .frequency   (frequency),
    .status      (status),
    .slot        (slot),
    .digit_bits  (digit_bits),
    .best_bits   (best_bits),
    .blocks_used (blocks_used),
    .found       (found)
  );

  assign last_result = status.last_slot;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while results pending");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> !in_ready)
    else $error("input not closed after last symbol");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_result |=> !out_valid && in_ready)
    else $error("results continue after final slot");

  a_slot_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid && slot == $past(slot) + 5'd1)
    else $error("slot sequence broken");

endmodule
